@@ src/rbd_pkg.sv @@
// Shared types and constants for the 2x2 RGB box downsampler.
// Used by rgb_box_downsample_2x2.sv and the bench; no dependencies.
package rbd_pkg;

	localparam int CFG_W          = 12;
	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam int CHAN_W = 8;
	localparam int LANE_W = CHAN_W + 1;
	localparam int PAIR_W = 3 * LANE_W;

	typedef struct packed {
		logic [CHAN_W-1:0] red_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_out;
		logic [CHAN_W-1:0] green_out;
		logic [CHAN_W-1:0] blue_out;
		logic              frame_end;
	} pix_out_t;

endpackage

@@ src/rbd_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rbd_ram #(
	parameter int WIDTH  = 27,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/rgb_box_downsample_2x2.sv @@
// 2x2 box-filter downsampler for a raster-order RGB888 stream.
// The odd-row, odd-column pixel passes the line RAM read and stage 1 registers, then the output register.
// Throughput: one pixel per cycle while in_stall is low, set by the single read and single write
// port of the half-line pair-sum RAM (reads on odd rows, writes on even rows).
// Reset: position counters and held pixel clear, size registers go to 640x480;
// line RAM contents are undefined until an even row writes them. Depends on rbd_pkg, rbd_ram.
module rgb_box_downsample_2x2 import rbd_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  pix_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output pix_out_t              out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int DEPTH  = MAX_WIDTH / 2;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW     = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW     = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WW     = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
	localparam int HW     = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
	localparam logic [WW-1:0] W_CAP = WW'((MAX_WIDTH / 2) * 2);
	localparam logic [HW-1:0] H_CAP = HW'((MAX_HEIGHT / 2) * 2);

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [3*CHAN_W-1:0] held_q;

	logic [WW-1:0] w_even;
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_even;
	logic [HW-1:0] h_eff;
	logic          col_last;
	logic          row_last;

	logic              in_acc;
	logic              out_free;
	logic              wr_en;
	logic              rd_en;
	logic [AW-1:0]     slot;
	logic [PAIR_W-1:0] pair;
	logic [PAIR_W-1:0] line_rdata;

	logic              valid_s1;
	logic [PAIR_W-1:0] pair_s1;
	logic              frame_end_s1;

	logic              out_valid_q;
	pix_out_t          out_data_q;
	pix_out_t          out_next;
	logic [LANE_W:0]   sum_r;
	logic [LANE_W:0]   sum_g;
	logic [LANE_W:0]   sum_b;

	logic cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_IMAGE_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_q);
			REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_q);
			default:          prdata = '0;
		endcase
	end

	// effective frame size
	always_comb begin
		w_even = WW'({width_q[CFG_W-1:1], 1'b0});
		h_even = HW'({height_q[CFG_W-1:1], 1'b0});
		if (w_even < WW'(2)) begin
			w_eff = WW'(2);
		end else if (w_even > W_CAP) begin
			w_eff = W_CAP;
		end else begin
			w_eff = w_even;
		end
		if (h_even < HW'(2)) begin
			h_eff = HW'(2);
		end else if (h_even > H_CAP) begin
			h_eff = H_CAP;
		end else begin
			h_eff = h_even;
		end
	end

	assign col_last = (WW'(col_q) + WW'(1)) >= w_eff;
	assign row_last = (HW'(row_q) + HW'(1)) >= h_eff;

	// handshake
	assign out_free = ~out_valid_q | ~out_stall;
	assign in_stall = valid_s1 & ~out_free;
	assign in_acc   = in_valid & ~in_stall;

	// position and held pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			held_q <= '0;
		end else if (in_acc) begin
			if (!col_q[0]) begin
				held_q <= in_data;
			end
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// horizontal pair sum, one 9-bit lane per channel
	assign pair = {
		LANE_W'(held_q[3*CHAN_W-1:2*CHAN_W]) + LANE_W'(in_data.red_in),
		LANE_W'(held_q[2*CHAN_W-1:CHAN_W])   + LANE_W'(in_data.green_in),
		LANE_W'(held_q[CHAN_W-1:0])          + LANE_W'(in_data.blue_in)
	};

	assign slot  = AW'(col_q >> 1);
	assign wr_en = in_acc & col_q[0] & ~row_q[0];
	assign rd_en = in_acc & col_q[0] & row_q[0];

	rbd_ram #(
		.WIDTH (PAIR_W),
		.DEPTH (DEPTH),
		.ADDR_W(AW)
	) u_line (
		.clk  (clk),
		.we   (wr_en),
		.waddr(slot),
		.wdata(pair),
		.re   (rd_en),
		.raddr(slot),
		.rdata(line_rdata)
	);

	// stage 1: wait for the line read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rd_en) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			pair_s1      <= pair;
			frame_end_s1 <= col_last & row_last;
		end
	end

	// vertical sum and divide by four
	always_comb begin
		sum_r = (LANE_W+1)'(line_rdata[3*LANE_W-1:2*LANE_W])
			+ (LANE_W+1)'(pair_s1[3*LANE_W-1:2*LANE_W]);
		sum_g = (LANE_W+1)'(line_rdata[2*LANE_W-1:LANE_W])
			+ (LANE_W+1)'(pair_s1[2*LANE_W-1:LANE_W]);
		sum_b = (LANE_W+1)'(line_rdata[LANE_W-1:0])
			+ (LANE_W+1)'(pair_s1[LANE_W-1:0]);
		out_next.red_out   = sum_r[LANE_W:2];
		out_next.green_out = sum_g[LANE_W:2];
		out_next.blue_out  = sum_b[LANE_W:2];
		out_next.frame_end = frame_end_s1;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			out_data_q <= out_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ bench/rgb_box_downsample_2x2_tb.sv @@
// Self-checking bench for the 2x2 RGB box downsampler: random pixel streams, idle
// gaps and output stalls, with size changes over APB between frames and mid-frame.
// Depends on rbd_pkg and the rgb_box_downsample_2x2 RTL.
`timescale 1ns / 100ps

module rgb_box_downsample_2x2_tb import rbd_pkg::*;;

	localparam int LINE_SLOTS     = DEF_MAX_WIDTH / 2;
	localparam int DRAIN_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT = 2000;

	class box_average_board;
		logic [LANE_W-1:0] pair_red[LINE_SLOTS];
		logic [LANE_W-1:0] pair_grn[LINE_SLOTS];
		logic [LANE_W-1:0] pair_blu[LINE_SLOTS];
		bit                line_written[LINE_SLOTS];
		pix_in_t           held_pix;
		int unsigned       col, row;
		logic [CFG_W-1:0]  width_reg, height_reg;
		pix_out_t          expected_avg[$];
		int unsigned       fail_count, pixel_count, result_count, frame_count;

		function new();
			foreach (pair_red[s]) begin
				pair_red[s] = '0;
				pair_grn[s] = '0;
				pair_blu[s] = '0;
				line_written[s] = 1'b0;
			end
			held_pix = '0;
			col = 0;
			row = 0;
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			fail_count = 0;
			pixel_count = 0;
			result_count = 0;
			frame_count = 0;
		endfunction

		function int unsigned span(logic [CFG_W-1:0] raw, int unsigned top);
			int unsigned v;
			v = {raw[CFG_W-1:1], 1'b0};
			if (v < 2) v = 2;
			if (v > top) v = top & ~1;
			return v;
		endfunction

		function void set_size(logic [0:0] index, logic [CFG_W-1:0] raw);
			if (index == REG_IMAGE_WIDTH) width_reg = raw;
			else height_reg = raw;
		endfunction

		// an odd row must only read slots that some even row has filled
		function bit width_fits(logic [CFG_W-1:0] raw);
			int unsigned w;
			w = span(raw, DEF_MAX_WIDTH);
			if ((row & 1) == 0) return 1'b1;
			for (int unsigned s = 0; s < w / 2; s++)
				if (!line_written[s]) return 1'b0;
			return 1'b1;
		endfunction

		function int unsigned left_in(bit whole_frame, int unsigned cap);
			int unsigned w, h, c, r, n;
			w = span(width_reg, DEF_MAX_WIDTH);
			h = span(height_reg, DEF_MAX_HEIGHT);
			c = col;
			r = row;
			n = 0;
			do begin
				n++;
				if (c + 1 >= w) begin
					c = 0;
					r = (r + 1 >= h) ? 0 : r + 1;
				end else begin
					c++;
				end
			end while (n < cap && !(c == 0 && (!whole_frame || r == 0)));
			return n;
		endfunction

		function void note_pixel(pix_in_t px);
			int unsigned w, h, slot;
			logic [LANE_W:0] r, g, b;
			pix_out_t avg;
			w = span(width_reg, DEF_MAX_WIDTH);
			h = span(height_reg, DEF_MAX_HEIGHT);
			slot = (col >> 1) % LINE_SLOTS;
			pixel_count++;
			if ((col & 1) == 0) begin
				held_pix = px;
			end else if ((row & 1) == 0) begin
				pair_red[slot] = LANE_W'(held_pix.red_in) + LANE_W'(px.red_in);
				pair_grn[slot] = LANE_W'(held_pix.green_in) + LANE_W'(px.green_in);
				pair_blu[slot] = LANE_W'(held_pix.blue_in) + LANE_W'(px.blue_in);
				line_written[slot] = 1'b1;
			end else begin
				r = (LANE_W+1)'(pair_red[slot]) + (LANE_W+1)'(held_pix.red_in)
					+ (LANE_W+1)'(px.red_in);
				g = (LANE_W+1)'(pair_grn[slot]) + (LANE_W+1)'(held_pix.green_in)
					+ (LANE_W+1)'(px.green_in);
				b = (LANE_W+1)'(pair_blu[slot]) + (LANE_W+1)'(held_pix.blue_in)
					+ (LANE_W+1)'(px.blue_in);
				avg.red_out = r[LANE_W:2];
				avg.green_out = g[LANE_W:2];
				avg.blue_out = b[LANE_W:2];
				avg.frame_end = (col + 1 >= w) && (row + 1 >= h);
				expected_avg.push_back(avg);
			end
			if (col + 1 >= w) begin
				col = 0;
				row = (row + 1 >= h) ? 0 : row + 1;
			end else begin
				col++;
			end
		endfunction

		function void compare_field(string label, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s expected %0d actual %0d", $time, label, want, got);
				fail_count++;
			end
		endfunction

		function void check_average(pix_out_t got);
			pix_out_t want;
			if (expected_avg.size() == 0) begin
				$display("%0t: unexpected output pixel %h", $time, got);
				fail_count++;
				return;
			end
			want = expected_avg.pop_front();
			result_count++;
			if (want.frame_end) frame_count++;
			compare_field("red_out", want.red_out, got.red_out);
			compare_field("green_out", want.green_out, got.green_out);
			compare_field("blue_out", want.blue_out, got.blue_out);
			compare_field("frame_end", want.frame_end, got.frame_end);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	pix_in_t               in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	pix_out_t              out_data;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	box_average_board board;
	bit               calm = 1'b0;
	int unsigned      sink_wait = 0;
	int unsigned      idle_cycles = 0;
	int unsigned      size_settings = 0;

	rgb_box_downsample_2x2 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	function automatic int unsigned pick_gap();
		return calm ? 0 : $urandom_range(0, 16);
	endfunction

	function automatic logic [CHAN_W-1:0] pick_level();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CHAN_W'($urandom);
		endcase
	endfunction

	function automatic pix_in_t random_pixel();
		pix_in_t p;
		p.red_in = pick_level();
		p.green_in = pick_level();
		p.blue_in = pick_level();
		return p;
	endfunction

	function automatic logic [CFG_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0: return CFG_W'($urandom_range(0, 1));
			1: return CFG_W'($urandom_range(18, 4095));
			default: return CFG_W'($urandom_range(2, 17));
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) board.note_pixel(in_data);
			if (out_valid && !out_stall) board.check_average(out_data);
		end
	end

	// hold off the next result for a drawn number of valid cycles
	always @(posedge clk) begin
		if (out_valid && !out_stall) sink_wait = pick_gap();
		if (sink_wait > 0) begin
			out_stall <= 1'b1;
			if (out_valid) sink_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
			idle_cycles = 0;
		end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
			$display("rgb_box_downsample_2x2_tb: FAIL");
			$finish;
		end
	end

	task automatic send_pixel(input pix_in_t px);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= px;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.expected_avg.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input bit is_write, input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= is_write;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_register(input logic [0:0] index, input logic [CFG_W-1:0] raw);
		logic [APB_ADDR_W-1:0] addr;
		logic [APB_DATA_W-1:0] word, back;
		addr = APB_ADDR_W'({index, 2'b00});
		word = {($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'd0, raw};
		apb_access(1'b1, addr, word, back);
		board.set_size(index, raw);
		@(posedge clk);
		apb_access(1'b0, addr, '0, back);
		board.compare_field(index == REG_IMAGE_WIDTH ? "image_width" : "image_height",
			raw, back);
	endtask

	task automatic resize(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
		int unsigned n;
		wait_quiet();
		if (!board.width_fits(w_raw)) begin
			n = board.left_in(1'b0, DEF_MAX_WIDTH + 1);
			repeat (n) send_pixel(random_pixel());
			wait_quiet();
		end
		set_register(REG_IMAGE_WIDTH, w_raw);
		@(posedge clk);
		set_register(REG_IMAGE_HEIGHT, h_raw);
		@(posedge clk);
		size_settings++;
	endtask

	initial begin
		int unsigned n, random_sent;
		logic [APB_DATA_W-1:0] back;
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_access(1'b0, APB_ADDR_W'({REG_IMAGE_WIDTH, 2'b00}), '0, back);
		board.compare_field("image_width after reset", WIDTH_RESET, back);
		@(posedge clk);
		apb_access(1'b0, APB_ADDR_W'({REG_IMAGE_HEIGHT, 2'b00}), '0, back);
		board.compare_field("image_height after reset", HEIGHT_RESET, back);
		@(posedge clk);

		// start a 640-wide line, then shrink below the current column mid-frame
		repeat (4) send_pixel(pix_in_t'('1));
		repeat (6) send_pixel(random_pixel());
		resize(12'd5, 12'd1);
		send_pixel(random_pixel());
		repeat (2) send_pixel(pix_in_t'('1));
		repeat (2) send_pixel(pix_in_t'('0));
		resize(12'd0, 12'd0);
		repeat (4) send_pixel(pix_in_t'('0));
		resize(12'd1, 12'd3);
		repeat (4) send_pixel(random_pixel());

		resize(12'd4095, 12'd2);
		repeat (48) send_pixel(random_pixel());
		resize(12'd2, 12'd4095);
		repeat (48) send_pixel(random_pixel());

		random_sent = 0;
		while (random_sent < 500) begin
			calm = ($urandom_range(0, 5) == 0);
			resize(pick_size(), pick_size());
			n = board.left_in(1'b1, 121);
			if (n > 120 || $urandom_range(0, 3) == 0) n = $urandom_range(1, 40);
			repeat (n) send_pixel(random_pixel());
			random_sent += n;
		end

		wait_quiet();
		$display("covered %0d pixels and %0d averaged blocks over %0d size settings,",
			board.pixel_count, board.result_count, size_settings);
		$display("%0d frame ends seen, with sizes clamped at both ends of the range",
			board.frame_count);
		if (board.fail_count == 0) begin
			$display("rgb_box_downsample_2x2_tb: PASS");
		end else begin
			$display("rgb_box_downsample_2x2_tb: FAIL");
		end
		$finish;
	end

endmodule

@@ rgb_box_downsample_2x2.f @@
src/rbd_pkg.sv
src/rbd_ram.sv
src/rgb_box_downsample_2x2.sv
bench/rgb_box_downsample_2x2_tb.sv
